/* design/mbps_pkg.sv */
package mbps_pkg;

   localparam int MAX_PATTERN_BYTES = 16;
   localparam int REGION_BYTES      = 262144;

   localparam int LANE_IDX_WIDTH = $clog2(MAX_PATTERN_BYTES);
   localparam int LEN_WIDTH      = 5;
   localparam int POS_WIDTH      = $clog2(REGION_BYTES) + 1;
   localparam int OFFSET_WIDTH   = 18;
   localparam int ADDR_WIDTH     = 16;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int PATTERN_BITS   = 8 * MAX_PATTERN_BYTES;

   // configuration register indexes
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_HIGH = 3'd1,
      CSR_IGNORE_LOW   = 3'd2,
      CSR_IGNORE_HIGH  = 3'd3,
      CSR_PATTERN_LEN  = 3'd4,
      CSR_ALIGN_MASK   = 3'd5,
      CSR_BASE_LOW     = 3'd6
   } csr_index_type;

   typedef logic [MAX_PATTERN_BYTES-1:0][7:0] window_type;

   // settings seen by the datapath, length already clamped to 1..max
   typedef struct packed {
      logic [PATTERN_BITS-1:0] pattern;
      logic [PATTERN_BITS-1:0] ignore;
      logic [LEN_WIDTH-1:0]    length;
      logic [ADDR_WIDTH-1:0]   align_mask;
      logic [ADDR_WIDTH-1:0]   base_low;
   } cfg_type;

   // request held between the window stage and the compare stage
   typedef struct packed {
      logic                    valid;
      logic                    last;
      logic                    eligible;
      logic [OFFSET_WIDTH-1:0] start;
   } stage_type;

   // masked compare of the newest length bytes of the window against the pattern
   function automatic logic pattern_hit(window_type win, cfg_type cfg);
      logic                      hit;
      logic [LEN_WIDTH:0]        idx_wide;
      logic [LANE_IDX_WIDTH-1:0] idx;
      logic [7:0]                care;
      hit = 1'b1;
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         idx_wide = (LEN_WIDTH+1)'(MAX_PATTERN_BYTES) - {1'b0, cfg.length}
                    + (LEN_WIDTH+1)'(j);
         idx      = idx_wide[LANE_IDX_WIDTH-1:0];
         care     = ~cfg.ignore[8*j +: 8];
         if ((LEN_WIDTH)'(j) < cfg.length) begin
            if ((win[idx] & care) != (cfg.pattern[8*j +: 8] & care)) begin
               hit = 1'b0;
            end
         end
      end
      return hit;
   endfunction

endpackage

/* design/mbps_csr.sv */
module mbps_csr
   import mbps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_write_data,
   output cfg_type                   cfg
);

   logic [63:0]           pat_low_ff, pat_high_ff, ign_low_ff, ign_high_ff;
   logic [LEN_WIDTH-1:0]  len_ff;
   logic [ADDR_WIDTH-1:0] align_ff, base_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         ign_low_ff  <= '0;
         ign_high_ff <= '0;
         len_ff      <= LEN_WIDTH'(MAX_PATTERN_BYTES);
         align_ff    <= ADDR_WIDTH'(1);
         base_ff     <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_write_data;
            CSR_PATTERN_HIGH: pat_high_ff <= csr_write_data;
            CSR_IGNORE_LOW:   ign_low_ff  <= csr_write_data;
            CSR_IGNORE_HIGH:  ign_high_ff <= csr_write_data;
            CSR_PATTERN_LEN:  len_ff      <= csr_write_data[LEN_WIDTH-1:0];
            CSR_ALIGN_MASK:   align_ff    <= csr_write_data[ADDR_WIDTH-1:0];
            CSR_BASE_LOW:     base_ff     <= csr_write_data[ADDR_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // clamp length into 1..max and pack the view
   always_comb begin
      cfg.pattern    = {pat_high_ff, pat_low_ff};
      cfg.ignore     = {ign_high_ff, ign_low_ff};
      cfg.align_mask = align_ff;
      cfg.base_low   = base_ff;
      if (len_ff == '0) begin
         cfg.length = LEN_WIDTH'(1);
      end else if (len_ff > LEN_WIDTH'(MAX_PATTERN_BYTES)) begin
         cfg.length = LEN_WIDTH'(MAX_PATTERN_BYTES);
      end else begin
         cfg.length = len_ff;
      end
   end

endmodule

/* design/mbps_window.sv */
module mbps_window
   import mbps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last_byte,
   input  logic [LEN_WIDTH-1:0] length,
   input  logic                 advance,
   output stage_type            stage,
   output window_type           window
);

   window_type           window_ff, window_in;
   logic [POS_WIDTH-1:0] pos_ff, pos_in, pos_next;
   stage_type            stage_ff, stage_in;
   logic                 accept, in_region;
   logic [POS_WIDTH-1:0] start_wide;

   assign req_ready = !stage_ff.valid || advance;
   assign accept    = req_valid && req_ready;
   assign in_region = pos_ff < POS_WIDTH'(REGION_BYTES);
   assign pos_next  = pos_ff + POS_WIDTH'(1);
   assign start_wide = pos_next - POS_WIDTH'(length);

   // shift window, advance position, load stage register
   always_comb begin
      window_in = window_ff;
      pos_in    = pos_ff;
      stage_in  = stage_ff;
      if (advance) begin
         stage_in.valid = 1'b0;
      end
      if (accept) begin
         if (in_region) begin
            for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
               window_in[i] = window_ff[i+1];
            end
            window_in[MAX_PATTERN_BYTES-1] = req_data_byte;
            pos_in = pos_next;
         end
         if (req_last_byte) begin
            pos_in = '0;
         end
         stage_in.valid    = 1'b1;
         stage_in.last     = req_last_byte;
         stage_in.eligible = in_region && (pos_next >= POS_WIDTH'(length));
         stage_in.start    = start_wide[OFFSET_WIDTH-1:0];
      end
   end

   // position and stage register, payload fields without reset
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.last     <= stage_in.last;
      stage_ff.eligible <= stage_in.eligible;
      stage_ff.start    <= stage_in.start;
   end

   // window register
   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   assign stage  = stage_ff;
   assign window = window_ff;

   // position saturates at the region size
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_WIDTH'(REGION_BYTES))
      else $error("byte position beyond region size");

   // a request past the region end never takes part in a compare
   assert property (@(posedge clock) disable iff (reset)
      accept && !in_region |=> !stage_ff.eligible)
      else $error("out-of-region byte marked eligible");

endmodule

/* design/mbps_match.sv */
module mbps_match
   import mbps_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  stage_type               stage,
   input  window_type              window,
   input  cfg_type                 cfg,
   output logic                    advance,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_found,
   output logic [OFFSET_WIDTH-1:0] rsp_match_offset
);

   logic                    reported_ff, reported_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    found_ff, found_in;
   logic [OFFSET_WIDTH-1:0] offset_ff, offset_in;
   logic [ADDR_WIDTH-1:0]   match_addr;
   logic                    align_ok, hit, produce, out_free;

   // masked compare and alignment of the match address
   assign match_addr = cfg.base_low + stage.start[ADDR_WIDTH-1:0];
   assign align_ok   = (match_addr & cfg.align_mask) == '0;
   assign hit        = stage.valid && stage.eligible && !reported_ff && align_ok
                       && pattern_hit(window, cfg);
   assign produce    = hit || (stage.valid && stage.last && !reported_ff);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign advance    = stage.valid && (!produce || out_free);

   // result register and per-stream report flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      found_in     = found_ff;
      offset_in    = offset_ff;
      reported_in  = reported_ff;
      if (advance) begin
         if (produce) begin
            rsp_valid_in = 1'b1;
            found_in     = hit;
            offset_in    = hit ? stage.start : '0;
         end
         reported_in = stage.last ? 1'b0 : (reported_ff || hit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         reported_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         reported_ff  <= reported_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff  <= found_in;
      offset_ff <= offset_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_match_offset = offset_ff;

   // a not-found result carries offset zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !found_ff |-> offset_ff == '0)
      else $error("not-found result with nonzero offset");

   // a result never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      advance && produce |-> out_free)
      else $error("result register overrun");

   // end of stream clears the report flag
   assert property (@(posedge clock) disable iff (reset)
      advance && stage.last |=> !reported_ff)
      else $error("report flag survived end of stream");

endmodule

/* design/masked_byte_pattern_search.sv */
// Masked byte pattern search: bytes of a region arrive one request per cycle while the
// block is ready, and it returns one response per region, found with the offset of the
// first aligned masked match of up to 16 pattern bytes, or not found on the request marked
// last. A request passes two registers (window shift register, then the masked compare into
// the response register), and a new request is accepted every cycle unless a response
// stalls; a stalled response holds up the input only while the request in the compare stage
// would itself produce a response. Configuration must be written through the csr port only
// while no stream is in flight; the block itself does not enforce this.
module masked_byte_pattern_search
   import mbps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_last_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_found,
   output logic [OFFSET_WIDTH-1:0]   rsp_match_offset,
   input  logic                      csr_write_en,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_write_data
);

   cfg_type    cfg;
   stage_type  stage;
   window_type window;
   logic       advance;

   // configuration registers
   mbps_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   // byte window and stream position
   mbps_window u_window (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .length        (cfg.length),
      .advance       (advance),
      .stage         (stage),
      .window        (window)
   );

   // compare and response register
   mbps_match u_match (
      .clock            (clock),
      .reset            (reset),
      .stage            (stage),
      .window           (window),
      .cfg              (cfg),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset)
   );

endmodule

/* tb/sv/tb_masked_byte_pattern_search.sv */
module tb_masked_byte_pattern_search;
   import mbps_pkg::*;

   localparam int SETTLE_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 105;

   // one search result as it leaves the block
   typedef struct packed {
      logic                    found;
      logic [OFFSET_WIDTH-1:0] offset;
   } search_outcome_t;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_t;

   // one line of the directed table: a register write or a request
   typedef struct packed {
      row_kind_t                 kind;
      csr_index_type             idx;
      logic [CSR_DATA_WIDTH-1:0] value;
      logic [7:0]                data;
      logic                      last;
      logic                      typed;
      logic                      typed_has;
      search_outcome_t           typed_res;
   } stim_row_t;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [7:0]                req_data_byte = '0;
   logic                      req_last_byte = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_found;
   logic [OFFSET_WIDTH-1:0]   rsp_match_offset;
   logic                      csr_write_en = 1'b0;
   logic [CSR_IDX_WIDTH-1:0]  csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data = '0;

   masked_byte_pattern_search DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow copy of the search settings
   logic [PATTERN_BITS-1:0] cfg_pattern = '0;
   logic [PATTERN_BITS-1:0] cfg_ignore  = '0;
   logic [LEN_WIDTH-1:0]    cfg_len     = 5'd16;
   logic [ADDR_WIDTH-1:0]   cfg_align   = 16'd1;
   logic [ADDR_WIDTH-1:0]   cfg_base    = '0;

   // shadow scan state
   logic [7:0]  scan_window [MAX_PATTERN_BYTES];
   int unsigned scan_pos = 0;
   bit          scan_reported = 1'b0;

   search_outcome_t pending_outcomes [$];
   stim_row_t       directed_rows [$];

   int  errors = 0;
   int  sent_items = 0;
   int  fed_items = 0;
   int  found_count = 0;
   int  missed_count = 0;
   int  settings_count = 0;
   bit  steady = 1'b0;
   bit  sent_since_drain = 1'b0;
   int  burst_left = 0;

   initial begin
      foreach (scan_window[i]) scan_window[i] = '0;
   end

   // predicted effect of one accepted request on the scan
   task automatic match_scan_byte(input logic [7:0] b, input logic lst, output bit took,
                                  output bit has_res, output search_outcome_t res);
      int unsigned len;
      int unsigned start;
      bit          hit;
      logic [7:0]  care;
      took    = lst;
      has_res = 1'b0;
      res     = '0;
      if (!scan_reported && scan_pos < REGION_BYTES) begin
         took = 1'b1;
         len  = (cfg_len == 0) ? 1 :
                ((cfg_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : cfg_len);
         for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) scan_window[i] = scan_window[i+1];
         scan_window[MAX_PATTERN_BYTES-1] = b;
         scan_pos++;
         if (scan_pos >= len) begin
            start = scan_pos - len;
            hit   = 1'b1;
            for (int j = 0; j < len; j++) begin
               care = ~cfg_ignore[8*j +: 8];
               if ((scan_window[MAX_PATTERN_BYTES-len+j] & care) !=
                   (cfg_pattern[8*j +: 8] & care)) hit = 1'b0;
            end
            // alignment is judged on the match address, not the region base
            if (hit && ((cfg_base + start) & cfg_align) == 0) begin
               res.found     = 1'b1;
               res.offset    = OFFSET_WIDTH'(start);
               has_res       = 1'b1;
               scan_reported = 1'b1;
            end
         end
      end
      if (lst) begin
         if (!has_res && !scan_reported) has_res = 1'b1;
         foreach (scan_window[i]) scan_window[i] = '0;
         scan_pos      = 0;
         scan_reported = 1'b0;
      end
   endtask

   // register write, shadow settings follow
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_PATTERN_LOW:  cfg_pattern[63:0]   = value;
         CSR_PATTERN_HIGH: cfg_pattern[127:64] = value;
         CSR_IGNORE_LOW:   cfg_ignore[63:0]    = value;
         CSR_IGNORE_HIGH:  cfg_ignore[127:64]  = value;
         CSR_PATTERN_LEN:  cfg_len             = value[LEN_WIDTH-1:0];
         CSR_ALIGN_MASK:   cfg_align           = value[ADDR_WIDTH-1:0];
         CSR_BASE_LOW:     cfg_base            = value[ADDR_WIDTH-1:0];
         default: ;
      endcase
   endtask

   // wait until the block has nothing left in flight
   task automatic settle();
      if (sent_since_drain) begin
         req_valid <= 1'b0;
         while (pending_outcomes.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
         sent_since_drain = 1'b0;
      end
   endtask

   // one request: bursty sender, then handshake and prediction
   task automatic push_request(input logic [7:0] b, input logic lst, input bit typed,
                               input bit typed_has, input search_outcome_t typed_res);
      int unsigned     gap;
      bit              took;
      bit              has_res;
      search_outcome_t res;
      if (!steady) begin
         if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= lst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      match_scan_byte(b, lst, took, has_res, res);
      if (typed) begin
         if (typed_has) pending_outcomes.push_back(typed_res);
      end else if (has_res) begin
         pending_outcomes.push_back(res);
      end
      sent_items++;
      if (took) fed_items++;
      sent_since_drain = 1'b1;
   endtask

   // random region: pattern-like bytes, planted copies, some broken
   task automatic random_stream();
      logic [7:0]  bytes [$];
      int unsigned span;
      int unsigned eff_len;
      int unsigned at;
      int unsigned lane;
      logic [7:0]  care;
      span    = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 32);
      eff_len = (cfg_len == 0) ? 1 :
                ((cfg_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : cfg_len);
      for (int i = 0; i < span; i++) begin
         if ($urandom_range(0, 1) == 1) begin
            lane = $urandom_range(0, eff_len - 1);
            care = ~cfg_ignore[8*lane +: 8];
            bytes.push_back((cfg_pattern[8*lane +: 8] & care) | (8'($urandom) & ~care));
         end else begin
            bytes.push_back(8'($urandom));
         end
      end
      if (span >= eff_len && $urandom_range(0, 3) != 0) begin
         repeat ($urandom_range(1, 2)) begin
            at = $urandom_range(0, span - eff_len);
            for (int j = 0; j < eff_len; j++) begin
               care = ~cfg_ignore[8*j +: 8];
               bytes[at+j] = (cfg_pattern[8*j +: 8] & care) | (8'($urandom) & ~care);
            end
            if ($urandom_range(0, 4) == 0)
               bytes[at + $urandom_range(0, eff_len - 1)] ^= 8'(1 << $urandom_range(0, 7));
         end
      end
      for (int i = 0; i < span; i++) push_request(bytes[i], i == span - 1, 1'b0, 1'b0, '0);
   endtask

   function automatic void add_csr(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] value);
      stim_row_t row;
      row       = '0;
      row.kind  = ROW_CSR;
      row.idx   = idx;
      row.value = value;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_byte(logic [7:0] data, logic last);
      stim_row_t row;
      row      = '0;
      row.kind = ROW_BYTE;
      row.data = data;
      row.last = last;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_known(logic [7:0] data, logic last, logic has, logic found,
                                     logic [OFFSET_WIDTH-1:0] offset);
      stim_row_t row;
      row                  = '0;
      row.kind             = ROW_BYTE;
      row.data             = data;
      row.last             = last;
      row.typed            = 1'b1;
      row.typed_has        = has;
      row.typed_res.found  = found;
      row.typed_res.offset = offset;
      directed_rows.push_back(row);
   endfunction

   // response checker
   always @(posedge clock) begin
      search_outcome_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected response found=%0b offset=%0d", $time,
                     rsp_found, rsp_match_offset);
            errors++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_found !== want.found) begin
               $display("%0t: found expected %0b actual %0b", $time, want.found, rsp_found);
               errors++;
            end
            if (rsp_match_offset !== want.offset) begin
               $display("%0t: match_offset expected %0d actual %0d", $time, want.offset,
                        rsp_match_offset);
               errors++;
            end
            if (want.found) found_count++;
            else missed_count++;
         end
      end
   end

   // receiver stall pattern: open stretches, coin flips, ready only when the two-bit tick is zero
   rx_mode_t    rx_mode = RX_OPEN;
   int unsigned rx_left = 0;
   logic [1:0]  rx_tick = '0;
   always @(posedge clock) begin
      rx_tick <= rx_tick + 2'd1;
      if (rx_left == 0) begin
         case ($urandom_range(0, 3))
            0, 1:    rx_mode <= RX_OPEN;
            2:       rx_mode <= RX_COIN;
            default: rx_mode <= RX_SPARSE;
         endcase
         rx_left <= $urandom_range(16, 96);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_ready <= (rx_tick == 2'd0);
         default:   rsp_ready <= 1'b1;
      endcase
   end

   // watchdog on handshake activity
   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d responses outstanding", $time,
                  WATCHDOG_LIMIT, pending_outcomes.size());
         $display("tb_masked_byte_pattern_search: errors");
         $finish;
      end
   end

   // stimulus
   initial begin
      stim_row_t             row;
      int unsigned           goal;
      logic [LEN_WIDTH-1:0]  len_val;
      logic [ADDR_WIDTH-1:0] align_val;
      logic [ADDR_WIDTH-1:0] base_val;
      logic [63:0]           ign_val [2];

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 16 byte pattern cannot complete in a one byte region
      add_known(8'h00, 1'b1, 1'b1, 1'b0, '0);
      // zero length acts as one byte, no alignment
      add_csr(CSR_PATTERN_LEN, 64'd0);
      add_csr(CSR_ALIGN_MASK, 64'd0);
      add_csr(CSR_PATTERN_LOW, 64'h0000_0000_0000_00FF);
      add_known(8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_known(8'hFF, 1'b1, 1'b1, 1'b1, 18'd1);
      // report mid-region, the rest is ignored and last gives nothing
      add_known(8'hFF, 1'b0, 1'b1, 1'b1, 18'd0);
      add_known(8'hFF, 1'b0, 1'b0, 1'b0, '0);
      add_known(8'h00, 1'b1, 1'b0, 1'b0, '0);
      // oversized length saturates to 16, every bit don't-care
      add_csr(CSR_PATTERN_LEN, 64'd31);
      add_csr(CSR_PATTERN_HIGH, '1);
      add_csr(CSR_IGNORE_LOW, '1);
      add_csr(CSR_IGNORE_HIGH, '1);
      for (int i = 0; i < 15; i++) add_byte((i % 2 == 1) ? 8'hFF : 8'h00, 1'b0);
      add_known(8'hFF, 1'b1, 1'b1, 1'b1, 18'd0);
      // widest alignment with base at the top of its range
      add_csr(CSR_IGNORE_LOW, 64'd0);
      add_csr(CSR_IGNORE_HIGH, 64'd0);
      add_csr(CSR_PATTERN_LEN, 64'd1);
      add_csr(CSR_PATTERN_LOW, 64'h0000_0000_0000_00AB);
      add_csr(CSR_ALIGN_MASK, 64'hFFFF);
      add_csr(CSR_BASE_LOW, 64'hFFFF);
      add_byte(8'hAB, 1'b0);
      add_byte(8'hAB, 1'b0);
      add_byte(8'h00, 1'b1);

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.kind == ROW_CSR) begin
            settle();
            write_csr(row.idx, row.value);
         end else begin
            push_request(row.data, row.last, row.typed, row.typed_has, row.typed_res);
         end
      end
      settings_count++;

      // random settings, each followed by a batch of regions
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         case ($urandom_range(0, 9))
            0:       len_val = 5'd0;
            1:       len_val = 5'($urandom_range(17, 31));
            2:       len_val = 5'd16;
            default: len_val = 5'($urandom_range(1, 16));
         endcase
         case ($urandom_range(0, 7))
            1:       align_val = 16'd1;
            2:       align_val = 16'd3;
            3:       align_val = 16'd7;
            4:       align_val = 16'd15;
            5:       align_val = 16'hFFFF;
            6:       align_val = 16'($urandom);
            default: align_val = 16'd0;
         endcase
         case ($urandom_range(0, 3))
            0:       base_val = 16'd0;
            1:       base_val = 16'hFFFF;
            default: base_val = 16'($urandom);
         endcase
         foreach (ign_val[h]) begin
            case ($urandom_range(0, 3))
               0:       ign_val[h] = '0;
               1:       ign_val[h] = '1;
               2:       ign_val[h] = {$urandom, $urandom};
               default: ign_val[h] = {$urandom, $urandom} & {$urandom, $urandom}
                                     & {$urandom, $urandom};
            endcase
         end
         // first batch: exact full-length matches
         if (p == 0) begin
            len_val    = 5'd16;
            align_val  = 16'd0;
            ign_val[0] = '0;
            ign_val[1] = '0;
         end
         write_csr(CSR_PATTERN_LOW, {$urandom, $urandom});
         write_csr(CSR_PATTERN_HIGH, {$urandom, $urandom});
         write_csr(CSR_IGNORE_LOW, ign_val[0]);
         write_csr(CSR_IGNORE_HIGH, ign_val[1]);
         write_csr(CSR_PATTERN_LEN, 64'(len_val));
         write_csr(CSR_ALIGN_MASK, 64'(align_val));
         write_csr(CSR_BASE_LOW, 64'(base_val));
         settings_count++;
         steady = (p % 4 == 3);
         goal   = sent_items + ITEMS_PER_PHASE;
         while (sent_items < goal) random_stream();
      end

      // drain and finish
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d requests (%0d scanned) over %0d register settings",
               sent_items, fed_items, settings_count);
      $display("responses checked: %0d found, %0d not found", found_count, missed_count);
      if (errors == 0) begin
         $display("tb_masked_byte_pattern_search: clean");
      end else begin
         $display("tb_masked_byte_pattern_search: errors");
      end
      $finish;
   end

endmodule
